@@ rtl/tstg_pkg.sv @@
// Shared types and constants for the TDMA slot transmit gate.
package tstg_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_CYCLE_PERIOD = 2'd0;
    localparam logic [1:0] CFG_SLOT_LENGTH  = 2'd1;
    localparam logic [1:0] CFG_OWN_SLOT     = 2'd2;
    localparam logic [1:0] CFG_TX_OFFSET    = 2'd3;

    // Configuration reset values
    localparam logic [15:0] CYCLE_PERIOD_RESET = 16'd10000;
    localparam logic [15:0] SLOT_LENGTH_RESET  = 16'd1000;
    localparam logic [7:0]  OWN_SLOT_RESET     = 8'd1;
    localparam logic [15:0] TX_OFFSET_RESET    = 16'd50;

    // Field widths
    localparam int CYCLE_W = 32;
    localparam int NOW_W   = 32;
    localparam int LEN_W   = 16;
    localparam int SLOT_W  = 8;

    // Request kinds carried on the input user field
    localparam logic OP_TIME_CHECK = 1'b0;
    localparam logic OP_BEACON     = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;       // capture the incoming request
        logic div_start;  // start the slot divider
        logic commit;     // update state and load the result register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic needs_div;  // captured request is a locked, ready time check
        logic div_done;   // divider has finished
    } t_dp_sts;

endpackage

@@ rtl/tstg_div.sv @@
// Restoring divider, one quotient bit per cycle, for the slot index and offset.
module tstg_div #(
    parameter int W = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [W-1:0]                i_dividend,
    input  logic [tstg_pkg::LEN_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [W-1:0]                o_quot,
    output logic [tstg_pkg::LEN_W-1:0]  o_rem
);
    localparam int CW = $clog2(W + 1);
    localparam int LW = tstg_pkg::LEN_W;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quot;
    logic [LW-1:0] r_rem;
    logic [LW-1:0] r_div;

    logic [LW:0]   w_shift;
    logic [LW+1:0] w_diff;
    logic          w_ge;

    // One trial subtraction per cycle
    assign w_shift = {r_rem, r_quot[W-1]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_div};
    assign w_ge    = ~w_diff[LW+1];

    // Control of the iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Quotient and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[W-2:0], w_ge};
            r_rem  <= w_ge ? w_diff[LW-1:0] : w_shift[LW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

@@ rtl/tstg_dp.sv @@
// Datapath: configuration, timing state, slot divider and result register.
module tstg_dp #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_index,
    input  logic [15:0]           i_cfg_wdata,
    input  logic                  i_op,
    input  logic [31:0]           i_now_ms,
    input  logic [31:0]           i_beacon_cycle,
    input  logic                  i_radio_ready,
    input  tstg_pkg::t_dp_cmd     i_cmd,
    output tstg_pkg::t_dp_sts     o_sts,
    output logic                  o_send_now,
    output logic                  o_locked
);
    localparam int W  = TIME_WIDTH;
    localparam int LW = tstg_pkg::LEN_W;

    // Configuration registers
    logic [LW-1:0]                   r_cycle_period;
    logic [LW-1:0]                   r_slot_length;
    logic [tstg_pkg::SLOT_W-1:0]     r_own_slot;
    logic [LW-1:0]                   r_tx_offset;

    // Captured request
    logic                            r_op;
    logic [W-1:0]                    r_now;
    logic [tstg_pkg::CYCLE_W-1:0]    r_cyc;
    logic                            r_rdy;

    // Timing state
    logic [W-1:0]                    r_beacon_time;
    logic [tstg_pkg::CYCLE_W-1:0]    r_current_cycle;
    logic                            r_seen;
    logic [tstg_pkg::CYCLE_W-1:0]    r_served_cycle;
    logic [W-1:0]                    r_grant_due;

    // Result register
    logic                            r_send;
    logic                            r_locked;

    logic [W-1:0]                    w_now;
    logic [LW-1:0]                   w_len;
    logic [W-1:0]                    w_since;
    logic                            w_div_done;
    logic [W-1:0]                    w_quot;
    logic [LW-1:0]                   w_rem;
    logic                            w_free_hit;
    logic                            w_slot_hit;

    // Time taken modulo 2^TIME_WIDTH
    generate
        if (W > tstg_pkg::NOW_W) begin : g_now_wide
            assign w_now = {{(W - tstg_pkg::NOW_W){1'b0}}, i_now_ms};
        end else if (W == tstg_pkg::NOW_W) begin : g_now_eq
            assign w_now = i_now_ms;
        end else begin : g_now_narrow
            assign w_now = i_now_ms[W-1:0];
        end
    endgenerate

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cycle_period <= tstg_pkg::CYCLE_PERIOD_RESET;
            r_slot_length  <= tstg_pkg::SLOT_LENGTH_RESET;
            r_own_slot     <= tstg_pkg::OWN_SLOT_RESET;
            r_tx_offset    <= tstg_pkg::TX_OFFSET_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tstg_pkg::CFG_CYCLE_PERIOD: r_cycle_period <= i_cfg_wdata;
                tstg_pkg::CFG_SLOT_LENGTH:  r_slot_length  <= i_cfg_wdata;
                tstg_pkg::CFG_OWN_SLOT:     r_own_slot     <= i_cfg_wdata[7:0];
                tstg_pkg::CFG_TX_OFFSET:    r_tx_offset    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Capture of the accepted request
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_now <= w_now;
            r_cyc <= i_beacon_cycle;
            r_rdy <= i_radio_ready;
        end
    end

    // Slot index and offset since the last beacon; a zero slot length acts as one
    assign w_len   = (r_slot_length == '0) ? LW'(1) : r_slot_length;
    assign w_since = r_now - r_beacon_time;

    tstg_div #(
        .W (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_since),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Grant decisions
    assign w_free_hit = (r_now >= r_grant_due);
    assign w_slot_hit = (w_quot == W'(r_own_slot)) && (w_rem >= r_tx_offset) &&
                        (r_served_cycle != r_current_cycle);

    // State update and result on commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beacon_time   <= '0;
            r_current_cycle <= '0;
            r_seen          <= 1'b0;
            r_served_cycle  <= '0;
            r_grant_due     <= '0;
        end else if (i_cmd.commit) begin
            if (r_op == tstg_pkg::OP_BEACON) begin
                r_seen          <= 1'b1;
                r_current_cycle <= r_cyc;
                r_beacon_time   <= r_now;
            end else if (r_rdy) begin
                if (!r_seen) begin
                    if (w_free_hit) begin
                        r_grant_due <= r_now + W'(r_cycle_period);
                    end
                end else if (w_slot_hit) begin
                    r_served_cycle <= r_current_cycle;
                end
            end
        end
    end

    // Result register, held until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_locked <= (r_op == tstg_pkg::OP_BEACON) | r_seen;
            if (r_op == tstg_pkg::OP_BEACON || !r_rdy) begin
                r_send <= 1'b0;
            end else if (!r_seen) begin
                r_send <= w_free_hit;
            end else begin
                r_send <= w_slot_hit;
            end
        end
    end

    assign o_sts.needs_div = (r_op == tstg_pkg::OP_TIME_CHECK) && r_rdy && r_seen;
    assign o_sts.div_done  = w_div_done;
    assign o_send_now      = r_send;
    assign o_locked        = r_locked;

endmodule

@@ rtl/tstg_ctrl.sv @@
// Controller: sequences one request through capture, divide where needed, and commit.
module tstg_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output tstg_pkg::t_dp_cmd  o_cmd,
    input  tstg_pkg::t_dp_sts  i_sts
);
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;
    logic       w_out_free;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;

    // Next state and commands
    always_comb begin
        n_state         = r_state;
        o_cmd.load      = 1'b0;
        o_cmd.div_start = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.needs_div) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            ST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (w_out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Output valid: set on commit, cleared when the result is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_tvalid = r_out_valid;

    // An accepted request always moves to the execute step
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_EXEC))
        else $error("accepted request did not enter execute");

    // The divider only finishes while the controller waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sts.div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide step");

    // A commit never overwrites a result that is still waiting
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> (!r_out_valid || i_m_tready))
        else $error("commit over an untaken result");

    // A new result appears only after a commit step
    a_valid_from_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_COMMIT))
        else $error("result valid without commit");

endmodule

@@ rtl/tdma_slot_transmit_gate.sv @@
// Top level of the TDMA slot transmit gate.
//
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tdata: now_ms, beacon_cycle,
//                                                    radio_ready; tuser: operation
// m_axis    out        m_axis_tvalid/m_axis_tready   tdata: send_now, locked
// cfg       in         i_cfg_we                      i_cfg_index, i_cfg_wdata
//
// One request at a time. A beacon, a time check with the radio not ready, or a
// time check before lock goes from capture through execute to commit. A locked
// time check also runs the one-bit-per-cycle slot divider between those steps.
// Reset (synchronous, active low) restores the configuration defaults and
// clears all timing state. A result waits in its output register while the
// next request is accepted; a stalled output holds the following commit.
module tdma_slot_transmit_gate #(
    parameter int TIME_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input requests
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // [31:0] now_ms, [63:32] beacon_cycle,
                                        // [64] radio_ready, [71:65] zero
    input  logic        s_axis_tuser,   // [0] operation
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] send_now, [1] locked, [7:2] zero
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    tstg_pkg::t_dp_cmd w_cmd;
    tstg_pkg::t_dp_sts w_sts;
    logic              w_send_now;
    logic              w_locked;

    tstg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    tstg_dp #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_op           (s_axis_tuser),
        .i_now_ms       (s_axis_tdata[31:0]),
        .i_beacon_cycle (s_axis_tdata[63:32]),
        .i_radio_ready  (s_axis_tdata[64]),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_send_now     (w_send_now),
        .o_locked       (w_locked)
    );

    assign m_axis_tdata = {6'b000000, w_locked, w_send_now};

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the TDMA slot transmit gate: scoreboard, drivers and test sequence.
`timescale 1ns / 100ps

module testbench;

    // Run limit in clock cycles, far above the slowest legal run.
    localparam int CYCLE_LIMIT = 600000;
    // Longest time from request to result, with margin.
    localparam int SETTLE_CYCLES = 48;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;    // [31:0] now_ms, [63:32] beacon_cycle,
                                  // [64] radio_ready, [71:65] zero
    logic        s_axis_tuser;    // [0] operation
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // [0] send_now, [1] locked, [7:2] zero
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_wdata;

    // Set during a stretch of the run in which neither side idles.
    logic        no_gaps = 1'b0;
    int          cycles = 0;
    logic [31:0] cycle_no = 32'd1;

    typedef struct packed {
        logic send_now;
        logic locked;
    } t_gate_result;

    // Tracks the gate state, predicts each result and checks the outputs.
    class grant_scoreboard;
        logic [15:0]  cycle_period;
        logic [15:0]  slot_len;
        logic [7:0]   own_slot;
        logic [15:0]  tx_offset;
        logic [31:0]  beacon_time;
        logic [31:0]  cur_cycle;
        logic         locked;
        logic [31:0]  served_cycle;
        logic [31:0]  grant_due;
        t_gate_result expected_grants[$];
        int           mismatches;

        function new();
            cycle_period = tstg_pkg::CYCLE_PERIOD_RESET;
            slot_len     = tstg_pkg::SLOT_LENGTH_RESET;
            own_slot     = tstg_pkg::OWN_SLOT_RESET;
            tx_offset    = tstg_pkg::TX_OFFSET_RESET;
            beacon_time  = '0;
            cur_cycle    = '0;
            locked       = 1'b0;
            served_cycle = '0;
            grant_due    = '0;
            mismatches   = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                tstg_pkg::CFG_CYCLE_PERIOD: cycle_period = val;
                tstg_pkg::CFG_SLOT_LENGTH:  slot_len = val;
                tstg_pkg::CFG_OWN_SLOT:     own_slot = val[7:0];
                tstg_pkg::CFG_TX_OFFSET:    tx_offset = val;
                default: ;
            endcase
        endfunction

        // Work out the result of one accepted request and queue it.
        function void note_request(logic op, logic [31:0] now, logic [31:0] cyc, logic ready);
            t_gate_result res;
            logic [31:0]  len_eff;
            logic [31:0]  since;
            logic [31:0]  slot;
            logic [31:0]  into;
            res.send_now = 1'b0;
            if (op == tstg_pkg::OP_BEACON) begin
                locked      = 1'b1;
                cur_cycle   = cyc;
                beacon_time = now;
            end else if (ready) begin
                if (!locked) begin
                    // Free-running fallback uses a plain unsigned compare.
                    if (now >= grant_due) begin
                        grant_due    = now + {16'b0, cycle_period};
                        res.send_now = 1'b1;
                    end
                end else begin
                    len_eff = (slot_len == 16'd0) ? 32'd1 : {16'b0, slot_len};
                    since   = now - beacon_time;
                    slot    = since / len_eff;
                    into    = since % len_eff;
                    if (slot == {24'b0, own_slot} && into >= {16'b0, tx_offset} &&
                        served_cycle != cur_cycle) begin
                        served_cycle = cur_cycle;
                        res.send_now = 1'b1;
                    end
                end
            end
            res.locked = locked;
            expected_grants.push_back(res);
        endfunction

        function void report(string what, logic want, logic got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0b, got %0b", what, want, got);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(logic [7:0] data);
            t_gate_result want;
            if (expected_grants.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %02h with nothing predicted", data);
                return;
            end
            want = expected_grants.pop_front();
            if (data[0] !== want.send_now)
                report("send_now", want.send_now, data[0]);
            if (data[1] !== want.locked)
                report("locked", want.locked, data[1]);
        endfunction

        function int pending();
            return expected_grants.size();
        endfunction
    endclass

    grant_scoreboard sb = new();

    tdma_slot_transmit_gate dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock: 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Result side back-pressure.
    always @(negedge i_clk) begin
        m_axis_tready <= no_gaps || ($urandom_range(0, 99) >= 33);
    end

    // Results are checked at the edge where they are taken.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    // Present one request, with random idle cycles first, and hold it until taken.
    task automatic send_request(logic op, logic [31:0] now, logic [31:0] cyc, logic ready);
        while (!no_gaps && $urandom_range(0, 99) < 33) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {7'b0, ready, cyc, now};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        sb.note_request(op, now, cyc, ready);
        @(negedge i_clk);
    endtask

    // Stop sending and wait for every outstanding result.
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
    endtask

    // Drain, let the block settle, then write all four registers.
    task automatic apply_settings(logic [15:0] period, logic [15:0] len, logic [7:0] own,
                                  logic [15:0] offset);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        idx = '{tstg_pkg::CFG_CYCLE_PERIOD, tstg_pkg::CFG_SLOT_LENGTH,
                tstg_pkg::CFG_OWN_SLOT, tstg_pkg::CFG_TX_OFFSET};
        // The upper byte of the slot write is junk that the block drops.
        val = '{period, len, {8'($urandom), own}, offset};
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        for (int i = 0; i < 4; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx[i];
            i_cfg_wdata <= val[i];
            @(negedge i_clk);
            sb.write_reg(idx[i], val[i]);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Distance from the beacon that lands near the node's own slot.
    function automatic logic [31:0] aim_since();
        logic [31:0] len_eff;
        logic [31:0] base;
        int          off;
        len_eff = (sb.slot_len == 16'd0) ? 32'd1 : {16'b0, sb.slot_len};
        base    = {24'b0, sb.own_slot} * len_eff;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return base + $urandom_range(0, len_eff - 1);
            4, 5, 6, 7: begin
                // Just around the transmit offset.
                off = int'(sb.tx_offset) + int'($urandom_range(0, 4)) - 2;
                if (off < 0)
                    off = 0;
                return base + 32'(off);
            end
            8: return base + len_eff + $urandom_range(0, len_eff - 1);
            default: begin
                if (sb.own_slot != 8'd0)
                    return base - len_eff + $urandom_range(0, len_eff - 1);
                return $urandom;
            end
        endcase
    endfunction

    // Time checks before lock, with a time base that mostly moves forward.
    task automatic run_fallback_phase(int n_items);
        logic [31:0] t;
        int          r;
        if ($urandom_range(0, 3) == 0)
            t = 32'hFFFF_0000 + $urandom_range(0, 65535);
        else
            t = $urandom_range(0, 1000);
        repeat (n_items) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                t = t + $urandom_range(0, 2 * int'(sb.cycle_period) + 2);
            else if (r < 9)
                t = $urandom;
            send_request(tstg_pkg::OP_TIME_CHECK, t, $urandom, $urandom_range(0, 99) < 80);
        end
    endtask

    // Mostly a beacon followed by aimed time checks, with some random noise.
    task automatic run_locked_phase(int n_items);
        int          sent;
        int          r;
        logic [31:0] bt;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 99) < 75) begin
                r = $urandom_range(0, 19);
                if (r == 0)
                    cycle_no = 32'd0;
                else if (r == 1)
                    cycle_no = cycle_no;
                else if (r == 2)
                    cycle_no = $urandom;
                else
                    cycle_no = cycle_no + 32'd1;
                bt = $urandom;
                send_request(tstg_pkg::OP_BEACON, bt, cycle_no, 1'($urandom_range(0, 1)));
                sent++;
                repeat ($urandom_range(2, 5)) begin
                    send_request(tstg_pkg::OP_TIME_CHECK, bt + aim_since(), $urandom,
                                 $urandom_range(0, 99) < 85);
                    sent++;
                end
            end else begin
                send_request(1'($urandom_range(0, 1)), $urandom, $urandom,
                             1'($urandom_range(0, 1)));
                sent++;
            end
        end
    endtask

    // Test sequence.
    initial begin
        logic [15:0] len;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = tstg_pkg::OP_TIME_CHECK;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = tstg_pkg::CFG_CYCLE_PERIOD;
        i_cfg_wdata   = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fallback at reset settings: grants once per period, ignores a busy radio,
        // and the next grant time wraps while the compare does not.
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd0, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd0, 32'hFFFF_FFFF, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd10000, 32'd0, 1'b0);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd10000, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'hFFFF_FFFF, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd9998, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd9999, 32'd0, 1'b1);

        // A zero period: the next grant time left from the checks before is kept, so these checks do not reach it.
        apply_settings(16'd0, tstg_pkg::SLOT_LENGTH_RESET, tstg_pkg::OWN_SLOT_RESET,
                       tstg_pkg::TX_OFFSET_RESET);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd5, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd5, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd6, 32'd0, 1'b1);

        // Longest period.
        apply_settings(16'hFFFF, tstg_pkg::SLOT_LENGTH_RESET, tstg_pkg::OWN_SLOT_RESET,
                       tstg_pkg::TX_OFFSET_RESET);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd100, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd65634, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd65635, 32'd0, 1'b1);

        // Random fallback traffic over a few periods.
        apply_settings(16'($urandom_range(1, 200)), 16'($urandom), 8'($urandom), 16'($urandom));
        run_fallback_phase(25);
        apply_settings(16'hFFFF, 16'($urandom), 8'($urandom), 16'($urandom));
        run_fallback_phase(25);
        apply_settings(16'($urandom_range(1, 65535)), tstg_pkg::SLOT_LENGTH_RESET,
                       tstg_pkg::OWN_SLOT_RESET, tstg_pkg::TX_OFFSET_RESET);
        run_fallback_phase(25);

        // Beacon handling at the reset slot settings.
        apply_settings(tstg_pkg::CYCLE_PERIOD_RESET, tstg_pkg::SLOT_LENGTH_RESET,
                       tstg_pkg::OWN_SLOT_RESET, tstg_pkg::TX_OFFSET_RESET);
        // A beacon with the radio busy still locks; cycle zero counts as served.
        send_request(tstg_pkg::OP_BEACON, 32'd1000, 32'd0, 1'b0);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd2060, 32'd0, 1'b1);
        // Largest cycle number, with the slot time wrapping past 2^32.
        send_request(tstg_pkg::OP_BEACON, 32'hFFFF_FC00, 32'hFFFF_FFFF, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'hFFFF_FC00 + 32'd1049, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'hFFFF_FC00 + 32'd1050, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'hFFFF_FC00 + 32'd1050, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'hFFFF_FC00 + 32'd2060, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_BEACON, 32'd5000, 32'd7, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd6999, 32'd0, 1'b0);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd6999, 32'd0, 1'b1);

        // A zero slot length behaves as one millisecond per slot.
        apply_settings(tstg_pkg::CYCLE_PERIOD_RESET, 16'd0, 8'd3, 16'd0);
        send_request(tstg_pkg::OP_BEACON, 32'd100, 32'd8, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd102, 32'd0, 1'b1);
        send_request(tstg_pkg::OP_TIME_CHECK, 32'd103, 32'd0, 1'b1);

        // Random locked traffic over several slot settings, extremes included.
        apply_settings(16'($urandom), 16'd1, 8'd0, 16'd0);
        run_locked_phase(48);
        apply_settings(16'($urandom), 16'hFFFF, 8'd255, 16'hFFFF);
        run_locked_phase(48);
        apply_settings(16'($urandom), 16'd0, 8'($urandom), 16'd0);
        run_locked_phase(48);

        // A stretch with no idling on either side.
        len = 16'($urandom_range(1, 300));
        apply_settings(16'($urandom), len, 8'($urandom), 16'($urandom_range(0, len - 1)));
        no_gaps = 1'b1;
        run_locked_phase(24);
        // Hold off the next request until the block has answered everything.
        wait_results();
        run_locked_phase(24);
        no_gaps = 1'b0;

        apply_settings(16'($urandom), 16'hFFFF, 8'd255, 16'd0);
        run_locked_phase(48);
        apply_settings(16'($urandom), 16'd1, 8'd255, 16'd0);
        run_locked_phase(48);
        len = 16'($urandom_range(1, 65535));
        apply_settings(16'($urandom), len, 8'($urandom), 16'($urandom_range(0, len - 1)));
        run_locked_phase(48);

        // Drain and report.
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tstg_pkg.sv
rtl/tstg_div.sv
rtl/tstg_dp.sv
rtl/tstg_ctrl.sv
rtl/tdma_slot_transmit_gate.sv
verif/testbench.sv
